// File: rtl/bfa_pkg.sv
package bfa_pkg;

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int PROTO_W = 8;
  localparam int LEN_W   = 16;
  localparam int SLOT_W  = 6;
  localparam int STAT_W  = 2;
  localparam int PKT_W   = 32;
  localparam int BYTE_W  = 48;

  localparam logic CMD_ACCOUNT = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  // Request held at the top level and broadcast to every cell during a pass.
  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [PORT_W-1:0] sport;
    logic [PORT_W-1:0] dport;
    logic [LEN_W-1:0]  len;
    logic [SLOT_W-1:0] ridx;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic              new_flow;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [PORT_W-1:0] port_a;
    logic [PORT_W-1:0] port_b;
    logic [PKT_W-1:0]  pkt_ab;
    logic [PKT_W-1:0]  pkt_ba;
    logic [BYTE_W-1:0] byte_ab;
    logic [BYTE_W-1:0] byte_ba;
  } res_t;

  // Record handed from cell to cell. Once done is set, later cells pass it unchanged.
  typedef struct packed {
    logic done;
    res_t res;
  } rec_t;

  function automatic logic [PKT_W-1:0] sat_inc(input logic [PKT_W-1:0] cnt);
    logic [PKT_W-1:0] r;
    r = (cnt == {PKT_W{1'b1}}) ? cnt : cnt + PKT_W'(1);
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] sat_add(input logic [BYTE_W-1:0] cnt,
                                                input logic [LEN_W-1:0]  len);
    logic [BYTE_W:0] sum;
    sum = {1'b0, cnt} + (BYTE_W+1)'(len);
    return sum[BYTE_W] ? {BYTE_W{1'b1}} : sum[BYTE_W-1:0];
  endfunction

endpackage

// File: rtl/bfa_cell.sv
module bfa_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bfa_pkg::req_t req,
  input  logic          in_active,
  input  bfa_pkg::rec_t in_rec,
  output logic          out_active,
  output bfa_pkg::rec_t out_rec
);

  localparam logic [bfa_pkg::SLOT_W-1:0] SLOT = bfa_pkg::SLOT_W'(CELL_INDEX % 64);

  logic                         valid_r, valid_nxt;
  logic [bfa_pkg::ADDR_W-1:0]   addr_a_r, addr_a_nxt, addr_b_r, addr_b_nxt;
  logic [bfa_pkg::PORT_W-1:0]   port_a_r, port_a_nxt, port_b_r, port_b_nxt;
  logic [bfa_pkg::PKT_W-1:0]    pkt_ab_r, pkt_ab_nxt, pkt_ba_r, pkt_ba_nxt;
  logic [bfa_pkg::BYTE_W-1:0]   byte_ab_r, byte_ab_nxt, byte_ba_r, byte_ba_nxt;
  logic                         active_r;
  bfa_pkg::rec_t                rec_r, rec_nxt;
  logic                         fwd_hit, rev_hit, slot_hit, capture, fresh;

  assign fwd_hit = valid_r && addr_a_r == req.src && port_a_r == req.sport &&
                   addr_b_r == req.dst && port_b_r == req.dport;
  assign rev_hit = valid_r && addr_a_r == req.dst && port_a_r == req.dport &&
                   addr_b_r == req.src && port_b_r == req.sport;
  assign slot_hit = valid_r && ({26'd0, req.ridx} == 32'(CELL_INDEX));

  always_comb begin
    valid_nxt   = valid_r;
    addr_a_nxt  = addr_a_r;
    addr_b_nxt  = addr_b_r;
    port_a_nxt  = port_a_r;
    port_b_nxt  = port_b_r;
    pkt_ab_nxt  = pkt_ab_r;
    pkt_ba_nxt  = pkt_ba_r;
    byte_ab_nxt = byte_ab_r;
    byte_ba_nxt = byte_ba_r;
    capture     = 1'b0;
    fresh       = 1'b0;
    rec_nxt     = in_rec;
    if (in_active && !in_rec.done) begin
      if (req.cmd == bfa_pkg::CMD_READ) begin
        capture = slot_hit;
      end else if (fwd_hit) begin
        // The A to B orientation wins when both orientations match.
        pkt_ab_nxt  = bfa_pkg::sat_inc(pkt_ab_r);
        byte_ab_nxt = bfa_pkg::sat_add(byte_ab_r, req.len);
        capture     = 1'b1;
      end else if (rev_hit) begin
        pkt_ba_nxt  = bfa_pkg::sat_inc(pkt_ba_r);
        byte_ba_nxt = bfa_pkg::sat_add(byte_ba_r, req.len);
        capture     = 1'b1;
      end else if (!valid_r) begin
        // Slots fill in order, so the first free cell is the next unused slot.
        valid_nxt   = 1'b1;
        addr_a_nxt  = req.src;
        addr_b_nxt  = req.dst;
        port_a_nxt  = req.sport;
        port_b_nxt  = req.dport;
        pkt_ab_nxt  = bfa_pkg::PKT_W'(1);
        pkt_ba_nxt  = '0;
        byte_ab_nxt = bfa_pkg::BYTE_W'(req.len);
        byte_ba_nxt = '0;
        capture     = 1'b1;
        fresh       = 1'b1;
      end
    end
    if (capture) begin
      rec_nxt.done         = 1'b1;
      rec_nxt.res.status   = bfa_pkg::STATUS_OK;
      rec_nxt.res.slot     = SLOT;
      rec_nxt.res.new_flow = fresh;
      rec_nxt.res.addr_a   = addr_a_nxt;
      rec_nxt.res.addr_b   = addr_b_nxt;
      rec_nxt.res.port_a   = port_a_nxt;
      rec_nxt.res.port_b   = port_b_nxt;
      rec_nxt.res.pkt_ab   = pkt_ab_nxt;
      rec_nxt.res.pkt_ba   = pkt_ba_nxt;
      rec_nxt.res.byte_ab  = byte_ab_nxt;
      rec_nxt.res.byte_ba  = byte_ba_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      active_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      active_r <= in_active;
    end
  end

  always_ff @(posedge clk) begin
    addr_a_r  <= addr_a_nxt;
    addr_b_r  <= addr_b_nxt;
    port_a_r  <= port_a_nxt;
    port_b_r  <= port_b_nxt;
    pkt_ab_r  <= pkt_ab_nxt;
    pkt_ba_r  <= pkt_ba_nxt;
    byte_ab_r <= byte_ab_nxt;
    byte_ba_r <= byte_ba_nxt;
    rec_r     <= rec_nxt;
  end

  assign out_active = active_r;
  assign out_rec    = rec_r;

endmodule

// File: rtl/bidirectional_flow_accounting_unit.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  cmd, addresses, ports, protocol, length, read index
// out_     output     out_valid/out_stall status, slot, new flag, key, packet and byte counts
//
// An account or read request walks a row of FLOW_ENTRIES cells, one cell per cycle, and
// its result then waits in the hold state for the output; an ignored protocol skips the row.
// One request is in flight at a time.
// Reset clears every slot's valid bit at once; no clearing pass is needed.
// A new request is taken while the previous result still waits under out_stall.
module bidirectional_flow_accounting_unit #(
  parameter int FLOW_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_source_port,
  input  logic [15:0] in_dest_port,
  input  logic [7:0]  in_ip_protocol,
  input  logic [15:0] in_byte_length,
  input  logic [5:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_slot,
  output logic        out_new_flow,
  output logic [31:0] out_side_a_address,
  output logic [31:0] out_side_b_address,
  output logic [15:0] out_side_a_port,
  output logic [15:0] out_side_b_port,
  output logic [31:0] out_packets_a_to_b,
  output logic [31:0] out_packets_b_to_a,
  output logic [47:0] out_bytes_a_to_b,
  output logic [47:0] out_bytes_b_to_a
);

  bfa_pkg::state_t state_r, state_nxt;
  bfa_pkg::req_t   req_r;
  bfa_pkg::res_t   tail_r, tail_nxt, out_r;
  logic            launch_r, launch_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept, counted, load_out;

  logic          act [FLOW_ENTRIES+1];
  bfa_pkg::rec_t rec [FLOW_ENTRIES+1];

  assign in_stall = (state_r != bfa_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign counted  = (in_cmd == bfa_pkg::CMD_READ) ||
                    (in_ip_protocol == bfa_pkg::PROTO_TCP) ||
                    (in_ip_protocol == bfa_pkg::PROTO_UDP);
  assign load_out = (state_r == bfa_pkg::ST_HOLD) && (!out_valid_r || !out_stall);

  assign act[0] = launch_r;
  assign rec[0] = '0;

  for (genvar i = 0; i < FLOW_ENTRIES; i++) begin : g_cell
    bfa_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .req        (req_r),
      .in_active  (act[i]),
      .in_rec     (rec[i]),
      .out_active (act[i+1]),
      .out_rec    (rec[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    tail_nxt      = tail_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      bfa_pkg::ST_IDLE: begin
        if (accept) begin
          if (counted) begin
            launch_nxt = 1'b1;
            state_nxt  = bfa_pkg::ST_RUN;
          end else begin
            tail_nxt        = '0;
            tail_nxt.status = bfa_pkg::STATUS_IGNORED;
            state_nxt       = bfa_pkg::ST_HOLD;
          end
        end
      end
      bfa_pkg::ST_RUN: begin
        if (act[FLOW_ENTRIES]) begin
          // A request that no cell took is either a read of an empty slot or a drop.
          if (rec[FLOW_ENTRIES].done) begin
            tail_nxt = rec[FLOW_ENTRIES].res;
          end else if (req_r.cmd == bfa_pkg::CMD_READ) begin
            tail_nxt        = '0;
            tail_nxt.status = bfa_pkg::STATUS_EMPTY;
            tail_nxt.slot   = req_r.ridx;
          end else begin
            tail_nxt        = '0;
            tail_nxt.status = bfa_pkg::STATUS_FULL;
          end
          state_nxt = bfa_pkg::ST_HOLD;
        end
      end
      bfa_pkg::ST_HOLD: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = bfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfa_pkg::ST_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r <= tail_nxt;
    if (accept) begin
      req_r.cmd   <= in_cmd;
      req_r.src   <= in_source_address;
      req_r.dst   <= in_dest_address;
      req_r.sport <= in_source_port;
      req_r.dport <= in_dest_port;
      req_r.len   <= in_byte_length;
      req_r.ridx  <= in_read_index;
    end
    if (load_out) begin
      out_r <= tail_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_slot           = out_r.slot;
  assign out_new_flow       = out_r.new_flow;
  assign out_side_a_address = out_r.addr_a;
  assign out_side_b_address = out_r.addr_b;
  assign out_side_a_port    = out_r.port_a;
  assign out_side_b_port    = out_r.port_b;
  assign out_packets_a_to_b = out_r.pkt_ab;
  assign out_packets_b_to_a = out_r.pkt_ba;
  assign out_bytes_a_to_b   = out_r.byte_ab;
  assign out_bytes_b_to_a   = out_r.byte_ba;

endmodule
